@@ hdl/utcsd_pkg.sv @@
// Shared constants, lookup tables and types for the UTC date-time difference block
`timescale 1ns / 1ps

package utcsd_pkg;

  // year window covered by the day and leap-second tables
  localparam int YEAR_SPAN = 128;
  localparam int BASE_YEAR = 1970;
  localparam int IDX_W     = $clog2(YEAR_SPAN);

  // field widths
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int DT_W    = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W;

  // internal widths: days since base year, seconds inside a day, absolute position
  localparam int YDAYS_W = 17;
  localparam int DCNT_W  = 18;
  localparam int TOD_W   = 17;
  localparam int LEAP_W  = 5;
  localparam int POS_W   = 35;
  localparam int DIFF_W  = POS_W + 1;
  localparam int OUT_W   = 33;

  localparam logic signed [POS_W-1:0] SECS_PER_DAY = POS_W'(86400);
  localparam logic signed [DIFF_W-1:0] SAT_HI = DIFF_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [DIFF_W-1:0] SAT_LO = -DIFF_W'(64'sd1 <<< (OUT_W - 1));

  localparam int JUNE_COUNT = 11;
  localparam int DEC_COUNT  = 16;
  localparam int JUNE_YEARS [JUNE_COUNT] = '{
    1972, 1981, 1982, 1983, 1985, 1992, 1993, 1994, 1997, 2012, 2015
  };
  localparam int DEC_YEARS [DEC_COUNT] = '{
    1972, 1973, 1974, 1975, 1976, 1977, 1978, 1979,
    1987, 1989, 1990, 1995, 1998, 2005, 2008, 2016
  };

  // month codes for the clamp bounds, the leap day and the June leap second
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_JUL = MONTH_W'(7);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } datetime_t;

  // per-stage load enables for the position pipeline
  typedef struct packed {
    logic ld_days;
    logic ld_pos;
  } pos_ctrl_t;

  typedef logic [YDAYS_W-1:0] ydays_arr_t [YEAR_SPAN];
  typedef logic [LEAP_W-1:0]  leap_arr_t  [YEAR_SPAN];
  typedef logic               flag_arr_t  [YEAR_SPAN];

  function automatic int days_before_year(int y);
    int n;
    n = y - 1;
    return 365 * n + n / 4 - n / 100 + n / 400;
  endfunction

  function automatic bit is_greg_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // days from the base year's first of January to each year's first of January
  function automatic ydays_arr_t build_year_days();
    ydays_arr_t t;
    for (int i = 0; i < YEAR_SPAN; i++) begin
      t[i] = YDAYS_W'(days_before_year(BASE_YEAR + i) - days_before_year(BASE_YEAR));
    end
    return t;
  endfunction

  // leap seconds already inserted before the first of January of each year
  function automatic leap_arr_t build_leap_base();
    leap_arr_t t;
    int        c;
    for (int i = 0; i < YEAR_SPAN; i++) begin
      c = 0;
      for (int j = 0; j < JUNE_COUNT; j++) begin
        if (JUNE_YEARS[j] < BASE_YEAR + i) c++;
      end
      for (int j = 0; j < DEC_COUNT; j++) begin
        if (DEC_YEARS[j] < BASE_YEAR + i) c++;
      end
      t[i] = LEAP_W'(c);
    end
    return t;
  endfunction

  // year has a leap second at the end of June
  function automatic flag_arr_t build_june_flag();
    flag_arr_t t;
    for (int i = 0; i < YEAR_SPAN; i++) begin
      t[i] = 1'b0;
      for (int j = 0; j < JUNE_COUNT; j++) begin
        if (JUNE_YEARS[j] == BASE_YEAR + i) t[i] = 1'b1;
      end
    end
    return t;
  endfunction

  function automatic flag_arr_t build_greg_flag();
    flag_arr_t t;
    for (int i = 0; i < YEAR_SPAN; i++) begin
      t[i] = is_greg_leap(BASE_YEAR + i);
    end
    return t;
  endfunction

  localparam ydays_arr_t YEAR_DAYS = build_year_days();
  localparam leap_arr_t  LEAP_BASE = build_leap_base();
  localparam flag_arr_t  JUNE_FLAG = build_june_flag();
  localparam flag_arr_t  GREG_FLAG = build_greg_flag();

  // days before the first of each month in a common year, index 1..12
  function automatic logic [8:0] days_before_month(logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/utcsd_position.sv @@
// Two-stage pipeline giving the seconds from the base epoch to one date-time
`timescale 1ns / 1ps

module utcsd_position
  import utcsd_pkg::*;
(
  input  logic                    clk,
  input  pos_ctrl_t               ctrl,
  input  datetime_t               dt,
  output logic signed [POS_W-1:0] pos
);

  logic [IDX_W-1:0]          yidx;
  logic [MONTH_W-1:0]        mon;
  logic [YDAYS_W-1:0]        ydays;
  logic                      greg;
  logic [LEAP_W-1:0]         leaps;
  logic                      june;
  logic signed [DCNT_W-1:0]  days_nxt;
  logic [TOD_W-1:0]          tod_nxt;
  logic signed [DCNT_W-1:0]  days_r;
  logic [TOD_W-1:0]          tod_r;
  logic signed [POS_W-1:0]   pos_nxt;
  logic signed [POS_W-1:0]   pos_r;

  // clamp year into the table window and month into 1..12
  always_comb begin
    if (dt.year < YEAR_W'(BASE_YEAR)) begin
      yidx = '0;
    end else if (dt.year > YEAR_W'(BASE_YEAR + YEAR_SPAN - 1)) begin
      yidx = IDX_W'(YEAR_SPAN - 1);
    end else begin
      yidx = IDX_W'(dt.year - YEAR_W'(BASE_YEAR));
    end
    if (dt.month < MONTH_JAN) begin
      mon = MONTH_JAN;
    end else if (dt.month > MONTH_DEC) begin
      mon = MONTH_DEC;
    end else begin
      mon = dt.month;
    end
  end

  // table lookups per year
  assign ydays = YEAR_DAYS[yidx];
  assign greg  = GREG_FLAG[yidx];
  assign leaps = LEAP_BASE[yidx];
  assign june  = JUNE_FLAG[yidx];

  // day count and seconds within the day, leap seconds folded in
  always_comb begin
    days_nxt = DCNT_W'(ydays) + DCNT_W'(days_before_month(mon))
             + DCNT_W'(greg && (mon > MONTH_FEB)) + DCNT_W'(dt.day) - DCNT_W'(1);
    tod_nxt  = TOD_W'(dt.hour) * TOD_W'(3600) + TOD_W'(dt.minute) * TOD_W'(60)
             + TOD_W'(dt.second) + TOD_W'(leaps) + TOD_W'(june && (mon >= MONTH_JUL));
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_days) begin
      days_r <= days_nxt;
      tod_r  <= tod_nxt;
    end
  end

  // scale days to seconds
  assign pos_nxt = POS_W'(days_r) * SECS_PER_DAY + $signed(POS_W'(tod_r));

  always_ff @(posedge clk) begin
    if (ctrl.ld_pos) begin
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

endmodule

@@ hdl/utc_seconds_between_datetimes.sv @@
// Top level: elapsed UTC seconds between two date-times, leap seconds included
`timescale 1ns / 1ps

// Takes one pair of UTC date-times per transfer and returns end minus start in SI
// seconds as a 33-bit signed value, counting Gregorian leap years and the leap
// seconds inserted from 1972 to 2016. Years are clamped to 1970..2097, months to
// 1..12; day, hour, minute and second are taken linearly. The block accepts a new
// transfer every cycle while the output is not stalled; its result passes through
// four registers in a row: an input register, a day-count stage, a days-to-seconds
// multiply stage and a subtract-and-saturate output register. Each stage holds when
// the one after it is full and stalled.

module utc_seconds_between_datetimes
  import utcsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_year, start_month, start_day, start_hour, start_minute, start_second,
  // end_year, end_month, end_day, end_hour, end_minute, end_second, zero pad
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // seconds_apart, zero pad
  output logic [39:0] out_tdata
);

  logic [2*DT_W-1:0]        in_r;
  logic                     v0_r;
  logic                     v1_r;
  logic                     v2_r;
  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_r;
  logic                     rdy_out;
  logic                     rdy2;
  logic                     rdy1;
  logic                     rdy0;
  pos_ctrl_t                ctrl;
  datetime_t                dt_start;
  datetime_t                dt_end;
  logic signed [POS_W-1:0]  pos_start;
  logic signed [POS_W-1:0]  pos_end;
  logic signed [DIFF_W-1:0] diff;
  logic [OUT_W-1:0]         out_nxt;

  // per-stage ready chain
  assign rdy_out   = !out_valid_r || out_tready;
  assign rdy2      = !v2_r || rdy_out;
  assign rdy1      = !v1_r || rdy2;
  assign rdy0      = !v0_r || rdy1;
  assign in_tready = rdy0;

  assign ctrl.ld_days = v0_r && rdy1;
  assign ctrl.ld_pos  = v1_r && rdy2;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_tvalid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy_out) out_valid_r <= v2_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_tvalid && rdy0) begin
      in_r <= in_tdata[2*DT_W-1:0];
    end
  end

  assign dt_start = datetime_t'(in_r[DT_W-1:0]);
  assign dt_end   = datetime_t'(in_r[2*DT_W-1:DT_W]);

  utcsd_position u_pos_start (
    .clk  (clk),
    .ctrl (ctrl),
    .dt   (dt_start),
    .pos  (pos_start)
  );

  utcsd_position u_pos_end (
    .clk  (clk),
    .ctrl (ctrl),
    .dt   (dt_end),
    .pos  (pos_end)
  );

  // difference and saturation to the output width
  always_comb begin
    diff = DIFF_W'(pos_end) - DIFF_W'(pos_start);
    if (diff > SAT_HI) begin
      out_nxt = OUT_W'(SAT_HI);
    end else if (diff < SAT_LO) begin
      out_nxt = OUT_W'(SAT_LO);
    end else begin
      out_nxt = diff[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(40 - OUT_W){1'b0}}, out_r};

  // input only backs up when the first stage holds an item
  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v0_r)
    else $error("input stalled with an empty first stage");

  // an accepted transfer lands in the first stage
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v0_r)
    else $error("accepted transfer lost at the input register");

  // a new result only comes from a filled multiply stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v2_r))
    else $error("result appeared without a source item");

  // a filled multiply stage reaches the output when it is free
  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && rdy_out |=> out_valid_r)
    else $error("multiply stage item not moved to the output");

endmodule

@@ verif/utcsd_gap_checker.sv @@
// Checker for the UTC date-time difference block: predicts each gap and compares results
`timescale 1ns / 1ps

module utcsd_gap_checker
  import utcsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // start_year, start_month, start_day, start_hour, start_minute, start_second,
  // end_year, end_month, end_day, end_hour, end_minute, end_second, zero pad
  input  logic [79:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // seconds_apart, zero pad
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending_count
);

  // years whose june or december end had an inserted second
  localparam int JUNE_LEAPS [JUNE_COUNT] = '{
    1972, 1981, 1982, 1983, 1985, 1992, 1993, 1994, 1997, 2012, 2015
  };
  localparam int DEC_LEAPS [DEC_COUNT] = '{
    1972, 1973, 1974, 1975, 1976, 1977, 1978, 1979,
    1987, 1989, 1990, 1995, 1998, 2005, 2008, 2016
  };
  // days ahead of the first of each month in a common year, index 1..12
  localparam int MONTH_START [13] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };
  localparam longint GAP_MAX = 64'sd4294967295;
  localparam longint GAP_MIN = -64'sd4294967296;

  logic signed [OUT_W-1:0] expected_gaps [$];
  logic signed [OUT_W-1:0] oldest_gap;

  // day count from 0001-01-01 to january 1st of year y
  function automatic longint days_to_jan1(longint y);
    longint n;
    n = y - 1;
    return 365 * n + n / 4 - n / 100 + n / 400;
  endfunction

  // seconds since 1970-01-01 00:00:00 utc, inserted seconds counted
  function automatic longint utc_offset(datetime_t t);
    longint y;
    longint m;
    longint days;
    longint leaps;
    y = longint'(t.year);
    m = longint'(t.month);
    if (y < BASE_YEAR) y = BASE_YEAR;
    if (y > BASE_YEAR + YEAR_SPAN - 1) y = BASE_YEAR + YEAR_SPAN - 1;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    days = days_to_jan1(y) - days_to_jan1(BASE_YEAR) + MONTH_START[m]
         + longint'(t.day) - 1;
    if (m > 2 && (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0))) days++;
    leaps = 0;
    for (int i = 0; i < JUNE_COUNT; i++) begin
      if (JUNE_LEAPS[i] < y || (JUNE_LEAPS[i] == y && m >= 7)) leaps++;
    end
    for (int i = 0; i < DEC_COUNT; i++) begin
      if (DEC_LEAPS[i] < y) leaps++;
    end
    return days * 86400 + longint'(t.hour) * 3600 + longint'(t.minute) * 60
         + longint'(t.second) + leaps;
  endfunction

  // end minus start, clamped to the 33-bit signed range
  function automatic logic signed [OUT_W-1:0] seconds_apart(datetime_t s, datetime_t e);
    longint d;
    d = utc_offset(e) - utc_offset(s);
    if (d > GAP_MAX) d = GAP_MAX;
    if (d < GAP_MIN) d = GAP_MIN;
    return d[OUT_W-1:0];
  endfunction

  // queue a prediction per input transfer, check each result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_gaps.delete();
      pending_count <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_gaps.push_back(seconds_apart(datetime_t'(in_tdata[DT_W-1:0]),
                                              datetime_t'(in_tdata[2*DT_W-1:DT_W])));
      end
      if (out_tvalid && out_tready) begin
        if (expected_gaps.size() == 0) begin
          $error("seconds_apart: transfer with nothing expected, expected none, actual %0d",
                 $signed(out_tdata[OUT_W-1:0]));
          fail_count++;
        end else begin
          oldest_gap = expected_gaps.pop_front();
          if (out_tdata[OUT_W-1:0] !== oldest_gap) begin
            $error("seconds_apart mismatch: expected %0d, actual %0d",
                   oldest_gap, $signed(out_tdata[OUT_W-1:0]));
            fail_count++;
          end
        end
      end
      pending_count <= expected_gaps.size();
    end
  end

endmodule

@@ verif/tb_utc_seconds_between_datetimes.sv @@
// Testbench top for the UTC date-time difference block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_utc_seconds_between_datetimes;
  import utcsd_pkg::*;

  localparam int RANDOM_PAIRS  = 650;
  localparam int PHASES        = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int SEND_IDLE [PHASES]  = '{0, 77, 0, 33};
  localparam int RECV_STALL [PHASES] = '{0, 0, 77, 33};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          cycle_count    = 0;

  always #5 clk = ~clk;

  utc_seconds_between_datetimes DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  utcsd_gap_checker gap_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic datetime_t make_datetime(int y, int mo, int d, int h, int mi, int s);
    datetime_t t;
    t.year   = YEAR_W'(y);
    t.month  = MONTH_W'(mo);
    t.day    = DAY_W'(d);
    t.hour   = HOUR_W'(h);
    t.minute = MIN_W'(mi);
    t.second = SEC_W'(s);
    return t;
  endfunction

  // mostly calendar-valid values, sometimes any bit pattern
  function automatic datetime_t random_datetime();
    datetime_t t;
    if ($urandom_range(9) == 0) begin
      t.year   = YEAR_W'($urandom);
      t.month  = MONTH_W'($urandom);
      t.day    = DAY_W'($urandom);
      t.hour   = HOUR_W'($urandom);
      t.minute = MIN_W'($urandom);
      t.second = SEC_W'($urandom);
    end else begin
      t.year   = ($urandom_range(1) == 0) ? YEAR_W'($urandom_range(2020, 1970))
                                          : YEAR_W'($urandom_range(2097, 1970));
      t.month  = MONTH_W'($urandom_range(12, 1));
      t.day    = DAY_W'($urandom_range(31, 1));
      t.hour   = HOUR_W'($urandom_range(23));
      t.minute = MIN_W'($urandom_range(59));
      t.second = ($urandom_range(15) == 0) ? SEC_W'(60) : SEC_W'($urandom_range(59));
    end
    return t;
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_pair(input datetime_t s, input datetime_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {(80 - 2 * DT_W)'(0), e, s};
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off until every expected result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    datetime_t s;
    datetime_t e;
    datetime_t t;
    int        y;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, both orders
    send_pair(make_datetime(0, 0, 0, 0, 0, 0), make_datetime(0, 0, 0, 0, 0, 0));
    send_pair(make_datetime(0, 0, 0, 0, 0, 0), make_datetime(4095, 15, 31, 31, 63, 63));
    send_pair(make_datetime(4095, 15, 31, 31, 63, 63), make_datetime(0, 0, 0, 0, 0, 0));
    send_pair(make_datetime(1970, 1, 1, 0, 0, 0), make_datetime(2097, 12, 31, 23, 59, 59));
    send_pair(make_datetime(2097, 12, 31, 23, 59, 59), make_datetime(1970, 1, 1, 0, 0, 0));
    send_pair(make_datetime(2001, 5, 5, 5, 5, 5), make_datetime(2001, 5, 5, 5, 5, 5));
    // inserted seconds at june and december ends
    send_pair(make_datetime(1972, 6, 30, 23, 59, 59), make_datetime(1972, 7, 1, 0, 0, 0));
    send_pair(make_datetime(1972, 6, 30, 23, 59, 60), make_datetime(1972, 7, 1, 0, 0, 0));
    send_pair(make_datetime(1972, 12, 31, 23, 59, 59), make_datetime(1973, 1, 1, 0, 0, 0));
    send_pair(make_datetime(2016, 12, 31, 23, 59, 60), make_datetime(2017, 1, 1, 0, 0, 0));
    send_pair(make_datetime(2015, 6, 30, 23, 59, 60), make_datetime(2015, 7, 1, 0, 0, 0));
    send_pair(make_datetime(1981, 6, 30, 0, 0, 0), make_datetime(1981, 7, 1, 0, 0, 0));
    // years outside the span clamp to its ends
    send_pair(make_datetime(1969, 3, 1, 0, 0, 0), make_datetime(1970, 3, 1, 0, 0, 0));
    send_pair(make_datetime(2097, 6, 1, 0, 0, 0), make_datetime(2098, 6, 1, 0, 0, 0));
    // month zero and months past december
    send_pair(make_datetime(1999, 0, 10, 0, 0, 0), make_datetime(1999, 1, 10, 0, 0, 0));
    send_pair(make_datetime(1999, 12, 10, 0, 0, 0), make_datetime(1999, 13, 10, 0, 0, 0));
    send_pair(make_datetime(1999, 15, 10, 0, 0, 0), make_datetime(1999, 14, 10, 0, 0, 0));
    // days, hours, minutes and seconds beyond their range run on linearly
    send_pair(make_datetime(2000, 3, 0, 0, 0, 0), make_datetime(2000, 2, 29, 0, 0, 0));
    send_pair(make_datetime(2001, 4, 31, 0, 0, 0), make_datetime(2001, 5, 1, 0, 0, 0));
    send_pair(make_datetime(2010, 8, 8, 31, 63, 63), make_datetime(2010, 8, 9, 0, 0, 0));
    // leap and common februaries
    send_pair(make_datetime(2096, 2, 29, 12, 0, 0), make_datetime(2096, 3, 1, 12, 0, 0));
    send_pair(make_datetime(2001, 2, 29, 12, 0, 0), make_datetime(2001, 3, 1, 12, 0, 0));
    send_pair(make_datetime(2000, 2, 28, 0, 0, 0), make_datetime(2000, 3, 1, 0, 0, 0));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      send_idle_pct = SEND_IDLE[p];
      recv_stall_pct <= RECV_STALL[p];
      for (int i = 0; i < RANDOM_PAIRS / PHASES; i++) begin
        case ($urandom_range(3))
          // straddle a june or december end where a second may be inserted
          0: begin
            y = $urandom_range(2017, 1971);
            if ($urandom_range(1) == 0) begin
              s = make_datetime(y, 6, 30, 23, 59, $urandom_range(60, 50));
              e = make_datetime(y, 7, 1, 0, 0, $urandom_range(9));
            end else begin
              s = make_datetime(y, 12, 31, 23, 59, $urandom_range(60, 50));
              e = make_datetime(y + 1, 1, 1, 0, 0, $urandom_range(9));
            end
          end
          // two date-times that differ at most in one field
          1: begin
            s = random_datetime();
            e = s;
            case ($urandom_range(4))
              0:       e.second = SEC_W'($urandom_range(60));
              1:       e.minute = MIN_W'($urandom_range(59));
              2:       e.day    = DAY_W'($urandom_range(31, 1));
              3:       e.month  = MONTH_W'($urandom_range(12, 1));
              default: e.year   = YEAR_W'($urandom_range(2097, 1970));
            endcase
          end
          default: begin
            s = random_datetime();
            e = random_datetime();
          end
        endcase
        if ($urandom_range(1) == 0) begin
          t = s;
          s = e;
          e = t;
        end
        send_pair(s, e);
        // sender holds off mid-phase until the pipeline is empty
        if (i == (RANDOM_PAIRS / PHASES) / 2) wait_idle();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ utc_seconds_between_datetimes.f @@
hdl/utcsd_pkg.sv
hdl/utcsd_position.sv
hdl/utc_seconds_between_datetimes.sv
verif/utcsd_gap_checker.sv
verif/tb_utc_seconds_between_datetimes.sv
